### rtl/tspe_pkg.sv
// ----------------------------------------------------------------------------
// tspe_pkg: shared types and constants for the transport stream extractor
// Packet framing constants, field widths and the result record.
// ----------------------------------------------------------------------------
package tspe_pkg;

  // Packets per batch (1..128)
  localparam int BATCH_PACKETS = 100;

  localparam int BYTE_W   = 8;
  localparam int PID_W    = 13;
  localparam int LEN_W    = 15;
  localparam int POS_W    = 8;
  localparam int PKT_W    = 7;
  localparam int PIDHI_W  = 5;
  localparam int AFC_W    = 2;

  localparam logic [BYTE_W-1:0] SYNC_VALUE    = 8'h47;
  localparam logic [POS_W-1:0]  LAST_POS      = 8'd187;
  localparam logic [POS_W-1:0]  NO_PAYLOAD    = 8'd188;
  localparam logic [POS_W-1:0]  BASE_PAYLOAD  = 8'd4;
  localparam logic [POS_W-1:0]  AFC_LEN_OFF   = 8'd5;
  localparam logic [BYTE_W-1:0] MAX_ADAPT_LEN = 8'd183;
  localparam logic [PKT_W-1:0]  LAST_PKT      = PKT_W'(BATCH_PACKETS - 1);

  // Header byte positions
  localparam logic [POS_W-1:0] POS_SYNC  = 8'd0;
  localparam logic [POS_W-1:0] POS_PIDHI = 8'd1;
  localparam logic [POS_W-1:0] POS_PIDLO = 8'd2;
  localparam logic [POS_W-1:0] POS_AFC   = 8'd3;
  localparam logic [POS_W-1:0] POS_ALEN  = 8'd4;

  // Adaptation field control codes
  typedef enum logic [AFC_W-1:0] {
    AFC_RESERVED   = 2'd0,
    AFC_PAYLOAD    = 2'd1,
    AFC_ADAPT_ONLY = 2'd2,
    AFC_ADAPT_PAYL = 2'd3
  } afc_e;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    logic              batch_done;
    logic [LEN_W-1:0]  batch_length;
  } result_t;

endpackage

### rtl/tspe_in_if.sv
// ----------------------------------------------------------------------------
// tspe_in_if: raw stream byte channel
// Valid/ready channel carrying one transport stream byte per request.
// ----------------------------------------------------------------------------
interface tspe_in_if
  import tspe_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

### rtl/tspe_out_if.sv
// ----------------------------------------------------------------------------
// tspe_out_if: extracted payload channel
// Valid/ready channel carrying one payload byte and/or batch report.
// ----------------------------------------------------------------------------
interface tspe_out_if
  import tspe_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic              payload_valid;
  logic              batch_done;
  logic [LEN_W-1:0]  batch_length;

  modport source (output valid, output payload_byte, output payload_valid,
                  output batch_done, output batch_length, input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input batch_done, input batch_length, output ready);
endinterface

### rtl/tspe_parser.sv
// ----------------------------------------------------------------------------
// tspe_parser: packet header parser and payload selector
// Tracks framing, parses the header, selects payload bytes and counts them.
// ----------------------------------------------------------------------------
module tspe_parser
  import tspe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PID_W-1:0]  cfg_pid_i,
  input  logic              fire_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic              res_valid_o,
  output result_t           res_o
);

  logic [PID_W-1:0]   pid_q;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [PKT_W-1:0]   pkt_q, pkt_d;
  logic               good_q, good_d;
  logic [PIDHI_W-1:0] pidhi_q, pidhi_d;
  logic               sel_q, sel_d;
  afc_e               afc_q, afc_d;
  logic [POS_W-1:0]   start_q, start_d;
  logic [LEN_W-1:0]   count_q, count_d;
  logic               emit;
  logic               done;
  logic               last_byte;
  logic [LEN_W-1:0]   count_inc;

  // Parse one byte against the current packet state
  always_comb begin
    good_d  = good_q;
    pidhi_d = pidhi_q;
    sel_d   = sel_q;
    afc_d   = afc_q;
    start_d = start_q;
    emit    = 1'b0;
    priority if (pos_q == POS_SYNC) begin
      good_d = (byte_i == SYNC_VALUE);
      sel_d  = 1'b0;
    end else if (pos_q == POS_PIDHI) begin
      if (byte_i[7]) begin
        good_d = 1'b0;
      end
      pidhi_d = byte_i[PIDHI_W-1:0];
    end else if (pos_q == POS_PIDLO) begin
      sel_d = good_q && ({pidhi_q, byte_i} == pid_q);
    end else if (pos_q == POS_AFC) begin
      afc_d = afc_e'(byte_i[5:4]);
      if (afc_e'(byte_i[5:4]) == AFC_ADAPT_ONLY) begin
        sel_d = 1'b0;
      end
      start_d = (afc_e'(byte_i[5:4]) == AFC_ADAPT_PAYL) ? NO_PAYLOAD : BASE_PAYLOAD;
    end else if (pos_q == POS_ALEN && afc_q == AFC_ADAPT_PAYL) begin
      start_d = (byte_i <= MAX_ADAPT_LEN) ? (AFC_LEN_OFF + byte_i) : NO_PAYLOAD;
    end else begin
      emit = sel_q && (pos_q >= start_q);
    end
  end

  // Framing counters and batch byte count
  always_comb begin
    last_byte = (pos_q >= LAST_POS);
    done      = last_byte && (pkt_q >= LAST_PKT);
    count_inc = count_q + LEN_W'(emit);
    pos_d     = last_byte ? '0 : pos_q + POS_W'(1);
    pkt_d     = pkt_q;
    if (last_byte) begin
      pkt_d = (pkt_q >= LAST_PKT) ? '0 : pkt_q + PKT_W'(1);
    end
    count_d = done ? '0 : count_inc;
  end

  // Build the result record
  always_comb begin
    res_valid_o         = fire_i && (emit || done);
    res_o.payload_byte  = emit ? byte_i : '0;
    res_o.payload_valid = emit;
    res_o.batch_done    = done;
    res_o.batch_length  = done ? count_inc : '0;
  end

  // Hold configuration and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_q   <= '0;
      pos_q   <= '0;
      pkt_q   <= '0;
      good_q  <= 1'b0;
      pidhi_q <= '0;
      sel_q   <= 1'b0;
      afc_q   <= AFC_RESERVED;
      start_q <= '0;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        pid_q <= cfg_pid_i;
      end
      if (fire_i) begin
        pos_q   <= pos_d;
        pkt_q   <= pkt_d;
        good_q  <= good_d;
        pidhi_q <= pidhi_d;
        sel_q   <= sel_d;
        afc_q   <= afc_d;
        start_q <= start_d;
        count_q <= count_d;
      end
    end
  end

endmodule

### rtl/tspe_out_buf.sv
// ----------------------------------------------------------------------------
// tspe_out_buf: result register with skid stage
// Two-entry output buffer so the input side keeps moving while a result waits.
// ----------------------------------------------------------------------------
module tspe_out_buf
  import tspe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    head_v_q, head_v_d;
  logic    skid_v_q, skid_v_d;
  result_t head_q, head_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop     = head_v_q && ready_i;
  assign ready_o = !skid_v_q;
  assign valid_o = head_v_q;
  assign data_o  = head_q;

  // Advance the head from the skid stage or the new result
  always_comb begin
    head_v_d = head_v_q;
    skid_v_d = skid_v_q;
    head_d   = head_q;
    skid_d   = skid_q;
    if (!head_v_q || pop) begin
      if (skid_v_q) begin
        head_d   = skid_q;
        head_v_d = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        head_d   = data_i;
        head_v_d = push_i;
      end
    end else if (push_i) begin
      skid_d   = data_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

### rtl/ts_pid_payload_extractor_top.sv
// ----------------------------------------------------------------------------
// ts_pid_payload_extractor_top: transport stream PID payload extractor
// Filters one PID out of a framed byte stream and passes its payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   byte_i   : raw stream bytes, one per request; 188-byte packets are framed
//              by a byte counter alone, BATCH_PACKETS packets to a batch.
//   result_o : one request per payload byte of the selected PID, and one on
//              the last byte of every batch carrying the batch's byte count
//              (both flags may be set on the same request).
//   audio_pid_we_i / audio_pid_i : PID to extract; write only while idle.
// Throughput is one byte per cycle while byte_i.ready is high, set by the single
// parse stage between the parser state registers and the result register.
// An accepted byte's result is registered in the output buffer before result_o.
// A two-entry output buffer (result register plus skid stage) lets input
// continue for one more result while result_o is stalled; byte_i.ready drops
// only when both entries are full. Bytes that yield no result are taken
// whenever ready is high.
// Reset clears framing, header state, the byte count and the PID to zero.
// ----------------------------------------------------------------------------
module ts_pid_payload_extractor_top
  import tspe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             audio_pid_we_i,
  input  logic [PID_W-1:0] audio_pid_i,
  tspe_in_if.sink          byte_i,
  tspe_out_if.source       result_o
);

  logic    fire;
  logic    res_valid;
  logic    buf_ready;
  result_t res;
  result_t head;

  assign byte_i.ready = buf_ready;
  assign fire         = byte_i.valid && buf_ready;

  tspe_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (audio_pid_we_i),
    .cfg_pid_i   (audio_pid_i),
    .fire_i      (fire),
    .byte_i      (byte_i.data_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tspe_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .ready_o (buf_ready),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .data_o  (head)
  );

  // Drive the result channel from the head entry
  assign result_o.payload_byte  = head.payload_byte;
  assign result_o.payload_valid = head.payload_valid;
  assign result_o.batch_done    = head.batch_done;
  assign result_o.batch_length  = head.batch_length;

endmodule

### tb/ts_pid_payload_extractor_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ts_pid_payload_extractor_top_tb: self-checking bench for the PID extractor
// Feeds framed 188-byte packets through the byte channel and mirrors the
// header parser, so that every payload byte and every batch report can be
// checked field by field.
//   - Directed packets cover the header corners: PID extremes, error bit,
//     the reserved and adaptation-only controls and the adaptation length
//     limits.
//   - Random packets follow, mostly well formed, with some noise, and the
//     PID changes mid-packet.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module ts_pid_payload_extractor_top_tb;
  import tspe_pkg::*;

  localparam int PACKET_LEN    = int'(LAST_POS) + 1;
  localparam int N_DIR         = 7;
  localparam int RAND_PACKETS  = 1;
  localparam int PHASE_PACKETS = 30;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int NONE          = -1;
  localparam int MAX_PRINTS    = 100;

  // Directed packet: optional PID write before it, header bytes, adaptation
  // length and the payload byte count read straight off the header.
  typedef struct packed {
    int                cfg_pid;
    logic [BYTE_W-1:0] sync;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
    logic [BYTE_W-1:0] alen;
    int                want;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR] = '{
    '{NONE,  8'h47, 8'h00, 8'h00, 8'h10, 8'h00, 184},  // reset PID 0 matches
    '{8191,  8'h47, 8'h1F, 8'hFF, 8'h30, 8'd182, 1},   // top PID, one byte left
    '{NONE,  8'h47, 8'h1F, 8'hFF, 8'h30, 8'd183, 0},   // field fills packet
    '{NONE,  8'h47, 8'h1F, 8'hFF, 8'h30, 8'd184, 0},   // length over limit
    '{NONE,  8'h47, 8'h9F, 8'hFF, 8'h10, 8'h00, 0},    // transport error
    '{NONE,  8'h47, 8'h1F, 8'hFF, 8'h00, 8'h00, 184},  // reserved control
    '{NONE,  8'h47, 8'h1F, 8'hFF, 8'h20, 8'h00, 0}     // adaptation only
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             pid_we;
  logic [PID_W-1:0] pid_val;

  tspe_in_if  byte_if ();
  tspe_out_if res_if ();

  ts_pid_payload_extractor_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .audio_pid_we_i (pid_we),
    .audio_pid_i    (pid_val),
    .byte_i         (byte_if),
    .result_o       (res_if)
  );

  // Parser mirror
  logic [PID_W-1:0]   filter_pid = '0;
  logic [POS_W-1:0]   pkt_pos    = '0;
  logic [PKT_W-1:0]   pkt_idx    = '0;
  logic               hdr_ok     = 1'b0;
  logic [PIDHI_W-1:0] pid_hi     = '0;
  logic               selected   = 1'b0;
  afc_e               afc_mode   = AFC_RESERVED;
  logic [POS_W-1:0]   pl_start   = '0;
  logic [LEN_W-1:0]   emitted    = '0;

  result_t awaited_extracts [$];

  logic [BYTE_W-1:0] pkt_buf [PACKET_LEN];
  int  err_count    = 0;
  int  payload_seen = 0;
  int  cycles       = 0;
  int  burst_left   = 0;
  int  sink_left    = 0;
  bit  src_idle     = 1'b1;
  bit  sink_stalls  = 1'b1;

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want_v);
    if (err_count < MAX_PRINTS)
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want_v);
    err_count++;
  endtask

  // Advance the parser mirror by one accepted byte and queue its result
  task automatic parse_stream_byte(input logic [BYTE_W-1:0] b);
    result_t          r;
    logic             emit;
    logic             last_of_batch;
    logic [PID_W-1:0] pid;
    emit = 1'b0;
    pid  = {pid_hi, b};
    if (pkt_pos == POS_SYNC) begin
      hdr_ok   = (b == SYNC_VALUE);
      selected = 1'b0;
    end else if (pkt_pos == POS_PIDHI) begin
      if (b[7]) hdr_ok = 1'b0;
      pid_hi = b[PIDHI_W-1:0];
    end else if (pkt_pos == POS_PIDLO) begin
      selected = hdr_ok && (pid == filter_pid);
    end else if (pkt_pos == POS_AFC) begin
      afc_mode = afc_e'(b[5:4]);
      if (afc_mode == AFC_ADAPT_ONLY) selected = 1'b0;
      pl_start = (afc_mode == AFC_ADAPT_PAYL) ? NO_PAYLOAD : BASE_PAYLOAD;
    end else if (pkt_pos == POS_ALEN && afc_mode == AFC_ADAPT_PAYL) begin
      pl_start = (b <= MAX_ADAPT_LEN) ? AFC_LEN_OFF + b : NO_PAYLOAD;
    end else if (selected && pkt_pos >= pl_start) begin
      emit    = 1'b1;
      emitted = emitted + 1'b1;
    end

    last_of_batch   = (pkt_pos >= LAST_POS) && (pkt_idx >= LAST_PKT);
    r.payload_byte  = emit ? b : '0;
    r.payload_valid = emit;
    r.batch_done    = last_of_batch;
    r.batch_length  = last_of_batch ? emitted : '0;
    if (emit || last_of_batch) awaited_extracts.push_back(r);

    // Framing comes from the byte counter alone
    if (pkt_pos >= LAST_POS) begin
      pkt_pos = '0;
      pkt_idx = (pkt_idx >= LAST_PKT) ? '0 : pkt_idx + 1'b1;
    end else begin
      pkt_pos = pkt_pos + 1'b1;
    end
    if (last_of_batch) emitted = '0;
  endtask

  // Offer one byte; when a burst ends, open a new one, after a random gap if src_idle
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = src_idle ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        byte_if.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 32);
    end
    @(negedge clk_i);
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    parse_stream_byte(b);
    burst_left--;
  endtask

  task automatic send_span(input int first, input int last);
    for (int i = first; i <= last; i++) send_byte(pkt_buf[i]);
  endtask

  // Hold the sender until every awaited result has arrived and settled
  task automatic drain_results();
    @(negedge clk_i);
    byte_if.valid <= 1'b0;
    while (awaited_extracts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_audio_pid(input logic [PID_W-1:0] v);
    @(negedge clk_i);
    pid_we  <= 1'b1;
    pid_val <= v;
    @(negedge clk_i);
    pid_we  <= 1'b0;
    filter_pid = v;
  endtask

  task automatic fill_packet(input logic [BYTE_W-1:0] s, b1, b2, b3, alen);
    for (int i = 0; i < PACKET_LEN; i++) pkt_buf[i] = BYTE_W'($urandom);
    pkt_buf[POS_SYNC]  = s;
    pkt_buf[POS_PIDHI] = b1;
    pkt_buf[POS_PIDLO] = b2;
    pkt_buf[POS_AFC]   = b3;
    if (afc_e'(b3[5:4]) == AFC_ADAPT_PAYL) pkt_buf[POS_ALEN] = alen;
  endtask

  // Mostly well-formed packets aimed at the filter PID, with some noise
  task automatic make_random_packet();
    logic [PID_W-1:0]  pid;
    logic [BYTE_W-1:0] alen;
    logic [BYTE_W-1:0] sync;
    afc_e              afc;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      for (int i = 0; i < PACKET_LEN; i++) pkt_buf[i] = BYTE_W'($urandom);
    end else begin
      pid  = filter_pid;
      pick = $urandom_range(0, 9);
      if (pick >= 8) pid = PID_W'($urandom);
      else if (pick == 7) pid = filter_pid ^ (PID_W'(1) << $urandom_range(0, PID_W-1));
      pick = $urandom_range(0, 9);
      afc  = (pick < 1) ? AFC_RESERVED : (pick < 6) ? AFC_PAYLOAD :
             (pick < 7) ? AFC_ADAPT_ONLY : AFC_ADAPT_PAYL;
      pick = $urandom_range(0, 15);
      alen = (pick == 0) ? 8'd0 : (pick == 1) ? MAX_ADAPT_LEN :
             (pick < 4) ? BYTE_W'($urandom_range(184, 255)) :
             BYTE_W'($urandom_range(0, 183));
      sync = ($urandom_range(0, 19) == 0) ? BYTE_W'($urandom) : SYNC_VALUE;
      fill_packet(sync, {($urandom_range(0, 15) == 0), 2'($urandom), pid[12:8]},
                  pid[7:0], {2'($urandom), afc, 4'($urandom)}, alen);
    end
  endtask

  // Receiver: runs of ready with short stalls between them
  always @(negedge clk_i) begin
    if (sink_left != 0) begin
      sink_left--;
    end else if (res_if.ready && sink_stalls) begin
      res_if.ready <= 1'b0;
      sink_left = $urandom_range(0, 3);
    end else begin
      res_if.ready <= 1'b1;
      sink_left = $urandom_range(0, 23);
    end
  end

  // Check each result request against the oldest awaited one
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (res_if.payload_valid) payload_seen++;
      if (awaited_extracts.size() == 0) begin
        report_mismatch("result with nothing awaited", res_if.payload_byte, 0);
      end else begin
        want = awaited_extracts.pop_front();
        if (res_if.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", res_if.payload_byte, want.payload_byte);
        if (res_if.payload_valid !== want.payload_valid)
          report_mismatch("payload_valid", res_if.payload_valid, want.payload_valid);
        if (res_if.batch_done !== want.batch_done)
          report_mismatch("batch_done", res_if.batch_done, want.batch_done);
        if (res_if.batch_length !== want.batch_length)
          report_mismatch("batch_length", res_if.batch_length, want.batch_length);
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int  split;
    int  mark;
    int  pick;
    logic [PID_W-1:0] next_pid;
    rst_ni            = 1'b0;
    pid_we            = 1'b0;
    pid_val           = '0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    res_if.ready      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed packets, each drained so its payload count can be checked
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].cfg_pid != NONE) write_audio_pid(PID_W'(dir_rows[i].cfg_pid));
      fill_packet(dir_rows[i].sync, dir_rows[i].b1, dir_rows[i].b2,
                  dir_rows[i].b3, dir_rows[i].alen);
      mark = payload_seen;
      send_span(0, PACKET_LEN - 1);
      drain_results();
      if (dir_rows[i].want != NONE && payload_seen - mark != dir_rows[i].want)
        report_mismatch("payload count of directed packet", payload_seen - mark,
                        dir_rows[i].want);
    end

    // Random packets; retune the PID mid-packet
    for (int k = 0; k < RAND_PACKETS; k++) begin
      make_random_packet();
      split = (k % PHASE_PACKETS == 0) ?
              $urandom_range(0, PACKET_LEN - 1) : PACKET_LEN;
      send_span(0, split - 1);
      if (split < PACKET_LEN) begin
        drain_results();
        pick     = $urandom_range(0, 3);
        next_pid = (pick == 0) ? '0 : (pick == 1) ? '1 : PID_W'($urandom);
        write_audio_pid(next_pid);
        src_idle    = ($urandom_range(0, 3) != 0);
        sink_stalls = ($urandom_range(0, 3) != 0);
        send_span(split, PACKET_LEN - 1);
      end
    end

    drain_results();
    if (awaited_extracts.size() != 0)
      report_mismatch("results never delivered", 0, awaited_extracts.size());
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
